// ===== rtl/gnb_pkg.sv =====
package gnb_pkg;

  localparam int NUM_CLASSES  = 3;
  localparam int NUM_FEATURES = 4;
  localparam int FEATURE_BITS = 16;
  localparam int MAX_SAMPLES  = 64;
  localparam int QUEUE_DEPTH  = 2;

  localparam int KIND_W   = 2;
  localparam int LABEL_W  = 2;
  localparam int STATUS_W = 2;
  localparam int CLASS_W  = 2;

  localparam int CIDX_W = $clog2(NUM_CLASSES);
  localparam int FIDX_W = $clog2(NUM_FEATURES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = FEATURE_BITS + $clog2(MAX_SAMPLES);
  localparam int SQ_W   = 2 * FEATURE_BITS + $clog2(MAX_SAMPLES);
  localparam int MEAN_W = FEATURE_BITS + 8;
  localparam int INV_W  = 32;
  localparam int LVS_W  = 32;

  localparam int D_W    = CNT_W + SQ_W;
  localparam int NN_W   = 2 * CNT_W;
  localparam int DIV_W  = (D_W > NN_W + INV_W) ? D_W : NN_W + INV_W;
  localparam int D2_W   = 2 * MEAN_W;
  localparam int HP_W   = D2_W + INV_W / 2;
  localparam int COST_W = D2_W + FIDX_W + 2;

  localparam int EXP_W  = $clog2(INV_W);
  localparam int LNB_W  = 22;
  localparam int LNF_W  = 28;

  localparam logic [15:0] LN2_FX = 16'd45426;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRAIN    = 2'd0,
    KIND_FINAL    = 2'd1,
    KIND_CLASSIFY = 2'd2,
    KIND_SKIP     = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLASSIFIED = 2'd0,
    ST_READY      = 2'd1,
    ST_FEW        = 2'd2,
    ST_NOT_READY  = 2'd3
  } status_e;

  typedef logic [FEATURE_BITS-1:0] feat_t;

  typedef struct packed {
    kind_e                        kind;
    feat_t [NUM_FEATURES-1:0]     feat;
    logic  [LABEL_W-1:0]          label;
  } cmd_t;

  // ln(1 + k/16) in unsigned 0.16, for k from 0 to 16.
  function automatic logic [15:0] ln_tab(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3973;
      5'd2:    v = 16'd7719;
      5'd3:    v = 16'd11262;
      5'd4:    v = 16'd14624;
      5'd5:    v = 16'd17821;
      5'd6:    v = 16'd20870;
      5'd7:    v = 16'd23783;
      5'd8:    v = 16'd26573;
      5'd9:    v = 16'd29248;
      5'd10:   v = 16'd31818;
      5'd11:   v = 16'd34292;
      5'd12:   v = 16'd36675;
      5'd13:   v = 16'd38975;
      5'd14:   v = 16'd41196;
      5'd15:   v = 16'd43345;
      5'd16:   v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/gaussian_naive_bayes_classifier.sv =====
// Gaussian naive Bayes classifier for three classes of four unsigned 8.8 features.
// A training request adds its sample to the per-class count, sums and sums of
// squares unless its class already holds 64 samples; it gives no result and
// runs a squaring and an accumulate step per feature in the back end. A
// finalize request gives one result: status 2 with the lowest class that holds
// fewer than two samples, or else status 1 after the means, inverse sample
// variances and log-variance sums have been computed, paced by the one
// bit-per-cycle divider, used twice for every entry with a nonzero variance
// term and once otherwise, and by the leading-one search of the logarithm. A
// classify request gives status 0 with the class of largest likelihood (lowest
// class on a tie), or status 3 unless the latest finalize succeeded; it runs a
// subtract, square, two-part multiply and accumulate chain for each class and
// feature. Requests of kind three, and training requests with a label out of
// range, are dropped at the input and never reach the back end.
// A two-entry queue sits between the input side and the back end, and the
// result sits in its own register, so new requests are taken while a result
// waits to be collected.
module gaussian_naive_bayes_classifier import gnb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [FEATURE_BITS-1:0] feature_a_i,
  input  logic [FEATURE_BITS-1:0] feature_b_i,
  input  logic [FEATURE_BITS-1:0] feature_c_i,
  input  logic [FEATURE_BITS-1:0] feature_d_i,
  input  logic [LABEL_W-1:0]      true_label_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [CLASS_W-1:0]      predicted_class_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // The front end decodes each request and queues those that matter.
  gnb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .feature_a_i  (feature_a_i),
    .feature_b_i  (feature_b_i),
    .feature_c_i  (feature_c_i),
    .feature_d_i  (feature_d_i),
    .true_label_i (true_label_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // The back end holds the model and carries out one request at a time.
  gnb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .predicted_class_o (predicted_class_o)
  );

endmodule

// ===== rtl/gnb_div.sv =====
module gnb_div import gnb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int ITER_W = $clog2(DIV_W + 1);

  logic              busy_q, done_q;
  logic [ITER_W-1:0] iter_q;
  logic [DIV_W-1:0]  rem_q, quo_q, div_q;
  logic [DIV_W:0]    shifted;
  logic              fits;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign fits    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= ITER_W'(DIV_W);
      end else if (busy_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_W'(shifted - {1'b0, div_q}) : shifted[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/gnb_front.sv =====
module gnb_front import gnb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [FEATURE_BITS-1:0] feature_a_i,
  input  logic [FEATURE_BITS-1:0] feature_b_i,
  input  logic [FEATURE_BITS-1:0] feature_c_i,
  input  logic [FEATURE_BITS-1:0] feature_d_i,
  input  logic [LABEL_W-1:0]      true_label_i,
  output logic                    cmd_valid_o,
  output cmd_t                    cmd_o,
  input  logic                    cmd_pop_i
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              keep, push, pop;
  cmd_t              in_cmd;

  // Requests that cannot change state or give a result are dropped here.
  always_comb begin
    case (kind_e'(kind_i))
      KIND_TRAIN:    keep = true_label_i < LABEL_W'(NUM_CLASSES);
      KIND_FINAL:    keep = 1'b1;
      KIND_CLASSIFY: keep = 1'b1;
      default:       keep = 1'b0;
    endcase
  end

  assign in_cmd.kind  = kind_e'(kind_i);
  assign in_cmd.feat  = {feature_d_i, feature_c_i, feature_b_i, feature_a_i};
  assign in_cmd.label = true_label_i;

  assign in_stall_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = cnt_q != '0;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_cmd;
    end
  end

endmodule

// ===== rtl/gnb_back.sv =====
module gnb_back import gnb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [CLASS_W-1:0]  predicted_class_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_TR_MUL, S_TR_ACC,
    S_FN_CHK, S_FN_MUL, S_FN_D, S_FN_INV, S_FN_MEAN_ST, S_FN_MEAN,
    S_LN_NORM, S_LN_MUL, S_LN_ACC,
    S_CL_SUB, S_CL_SQ, S_CL_MUL, S_CL_ACC,
    S_RESULT
  } state_e;

  state_e            state_q;
  logic [CIDX_W-1:0] ci_q;
  logic [FIDX_W-1:0] fi_q;
  logic [CNT_W-1:0]  count_q [NUM_CLASSES];
  logic [SUM_W-1:0]  sum_q   [NUM_CLASSES][NUM_FEATURES];
  logic [SQ_W-1:0]   sqsum_q [NUM_CLASSES][NUM_FEATURES];
  logic              ready_q, out_valid_q;
  status_e           res_status_q, status_q;
  logic [CIDX_W-1:0] res_class_q, pred_q;

  cmd_t                      cmd_q;
  logic [2*FEATURE_BITS-1:0] sqr_q;
  logic [D_W-1:0]            prod_a_q, prod_b_q;
  logic [NN_W-1:0]           nn_q;
  logic [INV_W-1:0]          inv_q, norm_q;
  logic [EXP_W-1:0]          exp_q;
  logic [LNB_W-1:0]          lnbase_q;
  logic [LNF_W-1:0]          lnfrac_q;
  logic signed [LVS_W-1:0]   lsum_q;
  logic [MEAN_W-1:0]         mean_q [NUM_CLASSES][NUM_FEATURES];
  logic [INV_W-1:0]          ivar_q [NUM_CLASSES][NUM_FEATURES];
  logic signed [LVS_W-1:0]   lvs_q  [NUM_CLASSES];
  logic [MEAN_W-1:0]         ad_q;
  logic [D2_W-1:0]           d2_q;
  logic [HP_W-1:0]           hi_q, lo_q;
  logic signed [COST_W-1:0]  cost_q, best_cost_q;
  logic [CIDX_W-1:0]         best_q;

  feat_t             x_cur;
  logic [CNT_W-1:0]  n_cur;
  logic [SUM_W-1:0]  s_cur;
  logic [SQ_W-1:0]   sq_cur;
  logic [D_W-1:0]    dval;
  logic              last_f, last_c;
  logic              few;
  logic [CIDX_W-1:0] few_cls;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_a, div_b, div_q;
  logic [INV_W-1:0]  sat_inv;
  logic [3:0]        ln_idx;
  logic [11:0]       ln_r;
  logic [15:0]       t_lo, t_hi, t_diff;
  logic [LNB_W:0]    ln_val;
  logic signed [LVS_W-1:0]  lsum_next;
  logic [MEAN_W-1:0] xs, m_cur;
  logic [INV_W-1:0]  iv_cur;
  logic [HP_W:0]     hsum;
  logic [D2_W-1:0]   term;
  logic signed [COST_W-1:0] cost_base, cost_next;
  logic              better;
  logic [CIDX_W-1:0] new_best;

  assign x_cur  = cmd_q.feat[fi_q];
  assign n_cur  = count_q[ci_q];
  assign s_cur  = sum_q[ci_q][fi_q];
  assign sq_cur = sqsum_q[ci_q][fi_q];
  assign dval   = prod_a_q - prod_b_q;
  assign last_f = fi_q == FIDX_W'(NUM_FEATURES - 1);
  assign last_c = ci_q == CIDX_W'(NUM_CLASSES - 1);

  always_comb begin
    few     = 1'b0;
    few_cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (count_q[c] < CNT_W'(2)) begin
        few     = 1'b1;
        few_cls = CIDX_W'(c);
      end
    end
  end

  // The divider serves the inverse variance, when its divisor is nonzero, and then the mean of each entry.
  assign div_start = (state_q == S_FN_D && dval != '0) || state_q == S_FN_MEAN_ST;
  assign div_a = (state_q == S_FN_D) ? DIV_W'({nn_q, {INV_W{1'b0}}})
                                     : DIV_W'({s_cur, 8'b0});
  assign div_b = (state_q == S_FN_D) ? DIV_W'(dval) : DIV_W'(n_cur);

  gnb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign sat_inv = (div_q[DIV_W-1:INV_W] != '0) ? '1 :
                   (div_q == '0) ? INV_W'(1) : div_q[INV_W-1:0];

  assign ln_idx    = norm_q[INV_W-2 -: 4];
  assign ln_r      = norm_q[INV_W-6 -: 12];
  assign t_lo      = ln_tab({1'b0, ln_idx});
  assign t_hi      = ln_tab({1'b0, ln_idx} + 5'd1);
  assign t_diff    = t_hi - t_lo;
  assign ln_val    = (LNB_W+1)'(lnbase_q) + (LNB_W+1)'(lnfrac_q >> 12);
  assign lsum_next = lsum_q + $signed(LVS_W'(20'd16 * LN2_FX)) - $signed(LVS_W'(ln_val));

  assign xs     = {x_cur, 8'b0};
  assign m_cur  = mean_q[ci_q][fi_q];
  assign iv_cur = ivar_q[ci_q][fi_q];
  assign hsum   = (HP_W+1)'(hi_q) + (HP_W+1)'(lo_q >> (INV_W / 2));
  assign term   = hsum[HP_W-1 -: D2_W];
  assign cost_base = (fi_q == '0) ? COST_W'(lvs_q[ci_q]) : cost_q;
  assign cost_next = cost_base + $signed(COST_W'(term));
  assign better    = (ci_q == '0) || (cost_next < best_cost_q);
  assign new_best  = better ? ci_q : best_q;

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ci_q         <= '0;
      fi_q         <= '0;
      ready_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_CLASSIFIED;
      pred_q       <= '0;
      res_status_q <= ST_CLASSIFIED;
      res_class_q  <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        count_q[c] <= '0;
        for (int f = 0; f < NUM_FEATURES; f++) begin
          sum_q[c][f]   <= '0;
          sqsum_q[c][f] <= '0;
        end
      end
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            fi_q <= '0;
            ci_q <= '0;
            case (cmd_i.kind)
              KIND_TRAIN: begin
                ci_q <= cmd_i.label[CIDX_W-1:0];
                if (count_q[cmd_i.label[CIDX_W-1:0]] < CNT_W'(MAX_SAMPLES)) begin
                  state_q <= S_TR_MUL;
                end
              end
              KIND_FINAL: state_q <= S_FN_CHK;
              KIND_CLASSIFY: begin
                if (ready_q) begin
                  state_q <= S_CL_SUB;
                end else begin
                  res_status_q <= ST_NOT_READY;
                  res_class_q  <= '0;
                  state_q      <= S_RESULT;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_TR_MUL: state_q <= S_TR_ACC;
        S_TR_ACC: begin
          sum_q[ci_q][fi_q]   <= s_cur + SUM_W'(x_cur);
          sqsum_q[ci_q][fi_q] <= sq_cur + SQ_W'(sqr_q);
          if (last_f) begin
            count_q[ci_q] <= n_cur + 1'b1;
            state_q       <= S_IDLE;
          end else begin
            fi_q    <= fi_q + 1'b1;
            state_q <= S_TR_MUL;
          end
        end
        S_FN_CHK: begin
          if (few) begin
            ready_q      <= 1'b0;
            res_status_q <= ST_FEW;
            res_class_q  <= few_cls;
            state_q      <= S_RESULT;
          end else begin
            state_q <= S_FN_MUL;
          end
        end
        S_FN_MUL: state_q <= S_FN_D;
        S_FN_D:   state_q <= (dval == '0) ? S_FN_MEAN_ST : S_FN_INV;
        S_FN_INV: begin
          if (div_done) begin
            state_q <= S_FN_MEAN_ST;
          end
        end
        S_FN_MEAN_ST: state_q <= S_FN_MEAN;
        S_FN_MEAN: begin
          if (div_done) begin
            state_q <= S_LN_NORM;
          end
        end
        S_LN_NORM: begin
          if (norm_q[INV_W-1]) begin
            state_q <= S_LN_MUL;
          end
        end
        S_LN_MUL: state_q <= S_LN_ACC;
        S_LN_ACC: begin
          if (last_f) begin
            fi_q <= '0;
            if (last_c) begin
              ready_q      <= 1'b1;
              res_status_q <= ST_READY;
              res_class_q  <= '0;
              state_q      <= S_RESULT;
            end else begin
              ci_q    <= ci_q + 1'b1;
              state_q <= S_FN_MUL;
            end
          end else begin
            fi_q    <= fi_q + 1'b1;
            state_q <= S_FN_MUL;
          end
        end
        S_CL_SUB: state_q <= S_CL_SQ;
        S_CL_SQ:  state_q <= S_CL_MUL;
        S_CL_MUL: state_q <= S_CL_ACC;
        S_CL_ACC: begin
          if (last_f) begin
            fi_q <= '0;
            if (last_c) begin
              res_status_q <= ST_CLASSIFIED;
              res_class_q  <= new_best;
              state_q      <= S_RESULT;
            end else begin
              ci_q    <= ci_q + 1'b1;
              state_q <= S_CL_SUB;
            end
          end else begin
            fi_q    <= fi_q + 1'b1;
            state_q <= S_CL_SUB;
          end
        end
        S_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            pred_q      <= res_class_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q <= cmd_i;
        end
      end
      S_TR_MUL: sqr_q <= (2*FEATURE_BITS)'(x_cur) * (2*FEATURE_BITS)'(x_cur);
      S_FN_CHK: lsum_q <= '0;
      S_FN_MUL: begin
        prod_a_q <= D_W'(n_cur) * D_W'(sq_cur);
        prod_b_q <= D_W'(s_cur) * D_W'(s_cur);
        nn_q     <= NN_W'(n_cur) * NN_W'(n_cur - 1'b1);
      end
      S_FN_D: begin
        if (dval == '0) begin
          inv_q <= '1;
        end
      end
      S_FN_INV: begin
        if (div_done) begin
          inv_q <= sat_inv;
        end
      end
      S_FN_MEAN: begin
        if (div_done) begin
          mean_q[ci_q][fi_q] <= div_q[MEAN_W-1:0];
          ivar_q[ci_q][fi_q] <= inv_q;
          norm_q             <= inv_q;
          exp_q              <= EXP_W'(INV_W - 1);
        end
      end
      S_LN_NORM: begin
        if (!norm_q[INV_W-1]) begin
          norm_q <= norm_q << 1;
          exp_q  <= exp_q - 1'b1;
        end
      end
      S_LN_MUL: begin
        lnfrac_q <= LNF_W'(t_diff) * LNF_W'(ln_r);
        lnbase_q <= LNB_W'(exp_q) * LNB_W'(LN2_FX) + LNB_W'(t_lo);
      end
      S_LN_ACC: begin
        if (last_f) begin
          lvs_q[ci_q] <= lsum_next;
          lsum_q      <= '0;
        end else begin
          lsum_q <= lsum_next;
        end
      end
      S_CL_SUB: ad_q <= (xs >= m_cur) ? xs - m_cur : m_cur - xs;
      S_CL_SQ:  d2_q <= D2_W'(ad_q) * D2_W'(ad_q);
      S_CL_MUL: begin
        hi_q <= HP_W'(d2_q) * HP_W'(iv_cur[INV_W-1 -: INV_W/2]);
        lo_q <= HP_W'(d2_q) * HP_W'(iv_cur[INV_W/2-1:0]);
      end
      S_CL_ACC: begin
        cost_q <= cost_next;
        if (last_f) begin
          best_q      <= new_best;
          best_cost_q <= better ? cost_next : best_cost_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = STATUS_W'(status_q);
  assign predicted_class_o = CLASS_W'(pred_q);

endmodule

// ===== rtl/gnb_checker.sv =====
module gnb_checker import gnb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [CLASS_W-1:0]  predicted_class_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(predicted_class_o))
    else $error("stalled result changed");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> predicted_class_o < CLASS_W'(NUM_CLASSES))
    else $error("class out of range");

  a_class_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_READY || status_o == ST_NOT_READY)
      |-> predicted_class_o == '0)
    else $error("class not zero for a status without a class");

endmodule

bind gaussian_naive_bayes_classifier gnb_checker u_gnb_checker (.*);

// ===== tb/gnb_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the classifier, keeps its own copy of the training
// state, works out the expected result of every accepted request and compares
// each collected result with the oldest one outstanding.
module gnb_monitor import gnb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [FEATURE_BITS-1:0] feature_a_i,
  input  logic [FEATURE_BITS-1:0] feature_b_i,
  input  logic [FEATURE_BITS-1:0] feature_c_i,
  input  logic [FEATURE_BITS-1:0] feature_d_i,
  input  logic [LABEL_W-1:0]      true_label_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [STATUS_W-1:0]     status_i,
  input  logic [CLASS_W-1:0]      predicted_class_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    status_e             status;
    logic [CLASS_W-1:0]  cls;
  } verdict_t;

  verdict_t verdict_q[$];

  longint unsigned sample_cnt [NUM_CLASSES];
  longint unsigned lin_sum    [NUM_CLASSES][NUM_FEATURES];
  longint unsigned sq_sum     [NUM_CLASSES][NUM_FEATURES];
  longint unsigned mean_fx    [NUM_CLASSES][NUM_FEATURES];
  longint unsigned inv_var_fx [NUM_CLASSES][NUM_FEATURES];
  longint          log_var_fx [NUM_CLASSES];
  bit              trained;

  // Natural log in 16.16 by a 17-entry table with linear interpolation.
  function automatic longint log_fixed(longint unsigned v);
    longint          tbl [0:16];
    int              e;
    longint unsigned frac;
    int              idx;
    longint          rem;
    tbl = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
            29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};
    if (v == 0) v = 1;
    e = 31;
    while (e > 0 && v[e] == 1'b0) e--;
    if (e >= 16) frac = (v >> (e - 16)) & 64'hFFFF;
    else frac = (v << (16 - e)) & 64'hFFFF;
    idx = int'(frac >> 12);
    rem = longint'(frac & 64'hFFF);
    return longint'(e) * 45426 + tbl[idx] + (((tbl[idx + 1] - tbl[idx]) * rem) >>> 12);
  endfunction

  function automatic longint unsigned inverse_variance(longint unsigned n,
                                                       longint unsigned s,
                                                       longint unsigned sq);
    longint unsigned disp;
    longint unsigned q;
    disp = n * sq - s * s;
    if (disp == 0) return 64'hFFFF_FFFF;
    q = ((n * (n - 1)) << 32) / disp;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    if (q == 0) q = 1;
    return q;
  endfunction

  function automatic verdict_t classify_outcome(logic [FEATURE_BITS-1:0] x [NUM_FEATURES]);
    verdict_t        v;
    longint          cost;
    longint          best_cost;
    longint          diff;
    longint unsigned d2;
    longint unsigned hi;
    longint unsigned lo;
    int              best;
    best = 0;
    best_cost = 0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cost = log_var_fx[c];
      for (int f = 0; f < NUM_FEATURES; f++) begin
        diff = longint'({40'd0, x[f], 8'd0}) - longint'(mean_fx[c][f]);
        if (diff < 0) diff = -diff;
        d2 = longint'(diff) * longint'(diff);
        hi = d2 * (inv_var_fx[c][f] >> 16);
        lo = d2 * (inv_var_fx[c][f] & 64'hFFFF);
        cost += longint'((hi + (lo >> 16)) >> 16);
      end
      if (c == 0 || cost < best_cost) begin
        best = c;
        best_cost = cost;
      end
    end
    v.status = ST_CLASSIFIED;
    v.cls = CLASS_W'(best);
    return v;
  endfunction

  // Applies one accepted request to the predicted state; returns 1 with the
  // expected verdict when the request gives a result.
  function automatic bit apply_request(kind_e kind, logic [FEATURE_BITS-1:0] x [NUM_FEATURES],
                                       logic [LABEL_W-1:0] label, output verdict_t v);
    longint lsum;
    v = '0;
    case (kind)
      KIND_TRAIN: begin
        if (label >= NUM_CLASSES) return 0;
        if (sample_cnt[label] >= MAX_SAMPLES) return 0;
        sample_cnt[label]++;
        for (int f = 0; f < NUM_FEATURES; f++) begin
          lin_sum[label][f] += x[f];
          sq_sum[label][f]  += longint'(x[f]) * longint'(x[f]);
        end
        return 0;
      end
      KIND_FINAL: begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (sample_cnt[c] < 2) begin
            trained = 0;
            v.status = ST_FEW;
            v.cls = CLASS_W'(c);
            return 1;
          end
        end
        for (int c = 0; c < NUM_CLASSES; c++) begin
          lsum = 0;
          for (int f = 0; f < NUM_FEATURES; f++) begin
            inv_var_fx[c][f] = inverse_variance(sample_cnt[c], lin_sum[c][f], sq_sum[c][f]);
            mean_fx[c][f] = ((lin_sum[c][f] << 8) / sample_cnt[c]) & 64'hFF_FFFF;
            lsum += 16 * 45426 - log_fixed(inv_var_fx[c][f]);
          end
          log_var_fx[c] = lsum;
        end
        trained = 1;
        v.status = ST_READY;
        return 1;
      end
      KIND_CLASSIFY: begin
        if (!trained) begin
          v.status = ST_NOT_READY;
          return 1;
        end
        v = classify_outcome(x);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [FEATURE_BITS-1:0] x [NUM_FEATURES];
    verdict_t                v;
    verdict_t                want;
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        sample_cnt[c] = 0;
        log_var_fx[c] = 0;
        for (int f = 0; f < NUM_FEATURES; f++) begin
          lin_sum[c][f] = 0;
          sq_sum[c][f] = 0;
          mean_fx[c][f] = 0;
          inv_var_fx[c][f] = 0;
        end
      end
      trained = 0;
      verdict_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // A result can only come from a request taken at an earlier edge, so
      // the output side is checked first.
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: status %0d class %0d", status_i, predicted_class_i);
        end else begin
          want = verdict_q.pop_front();
          if (status_i !== want.status || predicted_class_i !== want.cls) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected status %0d class %0d, got status %0d class %0d",
                       want.status, want.cls, status_i, predicted_class_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        x[0] = feature_a_i;
        x[1] = feature_b_i;
        x[2] = feature_c_i;
        x[3] = feature_d_i;
        if (apply_request(kind_e'(kind_i), x, true_label_i, v)) verdict_q.push_back(v);
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Top level of the classifier bench. It only produces requests, drives the
// result stall and gives the verdict; all prediction and comparison is done in
// the checker that sits beside the block.
module testbench;
  import gnb_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_stall;
  logic [KIND_W-1:0]       kind;
  logic [FEATURE_BITS-1:0] feature_a;
  logic [FEATURE_BITS-1:0] feature_b;
  logic [FEATURE_BITS-1:0] feature_c;
  logic [FEATURE_BITS-1:0] feature_d;
  logic [LABEL_W-1:0]      true_label;
  logic                    out_valid;
  logic                    out_stall;
  logic [STATUS_W-1:0]     status;
  logic [CLASS_W-1:0]      predicted_class;

  int fail_count;
  int pending;

  // Idle percentages for the two sides; the stimulus process changes them at
  // phase boundaries and the receiver process only reads its own one.
  int send_idle_pct;
  int recv_stall_pct;
  int sent_count;

  // Each class gets a centre and a spread per feature, so that most training
  // samples form separable clusters and classification has something to find.
  logic [FEATURE_BITS-1:0] centre [NUM_CLASSES][NUM_FEATURES];
  int                      spread [NUM_CLASSES][NUM_FEATURES];

  gaussian_naive_bayes_classifier dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .kind_i            (kind),
    .feature_a_i       (feature_a),
    .feature_b_i       (feature_b),
    .feature_c_i       (feature_c),
    .feature_d_i       (feature_d),
    .true_label_i      (true_label),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .predicted_class_o (predicted_class)
  );

  gnb_monitor u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .kind_i            (kind),
    .feature_a_i       (feature_a),
    .feature_b_i       (feature_b),
    .feature_c_i       (feature_c),
    .feature_d_i       (feature_d),
    .true_label_i      (true_label),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .status_i          (status),
    .predicted_class_i (predicted_class),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // The receiver stalls at random, and once, part-way through the run, it
  // holds off for a long stretch so that the queue and the result register
  // fill up and the block has to stall its input.
  int  hold_left;
  bit  hold_done;
  always @(posedge clk_i) begin
    if (!hold_done && sent_count >= 400) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one request and returns once it has been taken. The valid line is
  // only lowered when a gap is wanted, so back-to-back requests keep it high.
  task automatic send_request(kind_e k, logic [FEATURE_BITS-1:0] a, logic [FEATURE_BITS-1:0] b,
                              logic [FEATURE_BITS-1:0] c, logic [FEATURE_BITS-1:0] d,
                              logic [LABEL_W-1:0] label);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    feature_a  <= a;
    feature_b  <= b;
    feature_c  <= c;
    feature_d  <= d;
    true_label <= label;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent_count++;
  endtask

  function automatic logic [FEATURE_BITS-1:0] near_centre(int c, int f);
    int v;
    v = int'(centre[c][f]) + $urandom_range(2 * spread[c][f]) - spread[c][f];
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return FEATURE_BITS'(v);
  endfunction

  // A sample either from one class's cluster or uniform over the whole range.
  task automatic send_sample(kind_e k, logic [LABEL_W-1:0] label, bit clustered);
    logic [FEATURE_BITS-1:0] x [NUM_FEATURES];
    int                      c;
    c = (label < NUM_CLASSES) ? int'(label) : $urandom_range(NUM_CLASSES - 1);
    for (int f = 0; f < NUM_FEATURES; f++)
      x[f] = clustered ? near_centre(c, f) : FEATURE_BITS'($urandom);
    send_request(k, x[0], x[1], x[2], x[3], label);
  endtask

  initial begin
    int roll;
    int total;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    kind           = KIND_SKIP;
    feature_a      = '0;
    feature_b      = '0;
    feature_c      = '0;
    feature_d      = '0;
    true_label     = '0;
    send_idle_pct  = 33;
    recv_stall_pct = 54;
    sent_count     = 0;
    for (int c = 0; c < NUM_CLASSES; c++)
      for (int f = 0; f < NUM_FEATURES; f++) begin
        centre[c][f] = FEATURE_BITS'($urandom);
        spread[c][f] = $urandom_range(8192, 64);
      end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Classifying with no model must report it as not ready,
    // and finalizing with empty classes must name the lowest short class.
    send_request(KIND_CLASSIFY, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 2'd0);
    send_request(KIND_SKIP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    send_request(KIND_FINAL, '0, '0, '0, '0, 2'd0);
    // Extremes of the range in class zero, and a label out of range.
    send_request(KIND_TRAIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0);
    send_request(KIND_TRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0);
    send_request(KIND_TRAIN, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 2'd3);
    send_request(KIND_FINAL, '0, '0, '0, '0, 2'd0);
    // Class one gets two identical samples, which gives a zero variance.
    send_request(KIND_TRAIN, 16'h8000, 16'h0101, 16'hFEFE, 16'h7FFF, 2'd1);
    send_request(KIND_TRAIN, 16'h8000, 16'h0101, 16'hFEFE, 16'h7FFF, 2'd1);
    send_request(KIND_TRAIN, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 2'd2);
    send_request(KIND_FINAL, '0, '0, '0, '0, 2'd0);
    send_request(KIND_TRAIN, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 2'd2);
    send_request(KIND_CLASSIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0);
    send_request(KIND_FINAL, '0, '0, '0, '0, 2'd0);
    send_request(KIND_CLASSIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0);
    send_request(KIND_CLASSIFY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0);
    send_request(KIND_CLASSIFY, 16'h8000, 16'h0101, 16'hFEFE, 16'h7FFF, 2'd0);
    send_request(KIND_CLASSIFY, 16'h8000, 16'h0101, 16'hFEFE, 16'h7FFE, 2'd3);
    // Training after a finalize must not disturb the model in use.
    send_request(KIND_TRAIN, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 2'd0);
    send_request(KIND_CLASSIFY, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 2'd1);

    // Random part in three phases of idling. Most requests are clustered
    // training and classification, with finalizes spread through so that the
    // model is rebuilt often; once a class holds its maximum, further samples
    // for it are dropped, which the later phases exercise heavily.
    total = 850;
    for (int i = 0; i < total; i++) begin
      if (i == total / 3) begin
        send_idle_pct  = 54;
        recv_stall_pct = 33;
      end else if (i == 2 * total / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      roll = $urandom_range(99);
      if (roll < 48)
        send_sample(KIND_TRAIN, LABEL_W'($urandom_range(NUM_CLASSES - 1)), $urandom_range(3) != 0);
      else if (roll < 51)
        send_sample(KIND_TRAIN, LABEL_W'($urandom), 1'b0);
      else if (roll < 89)
        send_sample(KIND_CLASSIFY, LABEL_W'($urandom_range(3)), $urandom_range(4) != 0);
      else if (roll < 96)
        send_request(KIND_FINAL, FEATURE_BITS'($urandom), FEATURE_BITS'($urandom),
                     FEATURE_BITS'($urandom), FEATURE_BITS'($urandom), LABEL_W'($urandom));
      else
        send_sample(KIND_SKIP, LABEL_W'($urandom), 1'b0);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    // Let a trailing training request drain and catch any stray result.
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gnb_pkg.sv
rtl/gnb_div.sv
rtl/gnb_front.sv
rtl/gnb_back.sv
rtl/gaussian_naive_bayes_classifier.sv
rtl/gnb_checker.sv
tb/gnb_checker.sv
tb/testbench.sv
